/* design/hamming_matrix_codec_defines.svh */
// Assertion helpers for the codec. Each use expands to one labeled
// concurrent assertion clocked on clk and quiet while rst_n is low.
`ifndef HAMMING_MATRIX_CODEC_DEFINES_SVH
`define HAMMING_MATRIX_CODEC_DEFINES_SVH

// Same-cycle implication.
`define HMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hmc: same-cycle check failed");

// Next-cycle implication.
`define HMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hmc: next-cycle check failed");

`endif

/* design/hmc_pkg.sv */
package hmc_pkg;

  localparam int MAX_CODE_LENGTH = 31;
  localparam int MAX_CHECK_ROWS  = 5;

  localparam int WORD_W   = 31;
  localparam int POS_W    = 5;
  localparam int ROW_REGS = 5;
  localparam int ROW_W    = 3;   // check_count width and row select width
  localparam int IDX_W    = 3;   // config register index width
  localparam int ROW_CAP  = (MAX_CHECK_ROWS < ROW_REGS) ? MAX_CHECK_ROWS : ROW_REGS;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_CODE_LENGTH = 3'd0,
    REG_CHECK_COUNT = 3'd1,
    REG_ROW_ZERO    = 3'd2,
    REG_ROW_ONE     = 3'd3,
    REG_ROW_TWO     = 3'd4,
    REG_ROW_THREE   = 3'd5,
    REG_ROW_FOUR    = 3'd6
  } hmc_reg_t;

  localparam logic [POS_W-1:0] CODE_LENGTH_RST = 5'd7;
  localparam logic [ROW_W-1:0] CHECK_COUNT_RST = 3'd3;
  localparam logic [ROW_REGS-1:0][WORD_W-1:0] ROW_RST = {
    31'd0, 31'd0, 31'd85, 31'd102, 31'd120
  };

  typedef struct packed {
    logic  opcode;
    word_t payload;
  } hmc_in_t;

  typedef struct packed {
    word_t             result_word;
    word_t             data_bits;
    logic [POS_W-1:0]  syndrome_value;
    logic [POS_W-1:0]  error_position;
    logic              position_overflow;
  } hmc_out_t;

  // Tables derived from the matrix registers, rebuilt on every write.
  typedef struct packed {
    logic [POS_W-1:0]                 len;        // effective code length
    logic [ROW_W-1:0]                 rows;       // effective row count
    word_t                            len_mask;   // columns below len
    logic [ROW_REGS-1:0][WORD_W-1:0]  row_mask;   // active rows, cut to len
    logic [ROW_REGS-1:0][WORD_W-1:0]  first_par;  // lowest parity column per row
    word_t                            data_cols;  // non-parity columns
    word_t                            data_keep;  // low bits, one per data column
    logic [WORD_W-1:0][POS_W-1:0]     data_idx;   // data bit number of each column
  } hmc_cfg_t;

endpackage

/* design/hmc_cfg.sv */
module hmc_cfg
  import hmc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  word_t            cfg_wdata,
  output hmc_cfg_t         tab
);

  logic [POS_W-1:0]                code_length_r, code_length_nxt;
  logic [ROW_W-1:0]                check_count_r, check_count_nxt;
  logic [ROW_REGS-1:0][WORD_W-1:0] rows_r, rows_nxt;
  hmc_cfg_t                        tab_r, tab_nxt;

  logic [ROW_REGS-1:0]             col_bits;
  word_t                           par_cols;
  word_t                           low_mask;
  word_t                           pick;
  logic [POS_W:0]                  data_cnt;

  always_comb begin
    code_length_nxt = code_length_r;
    check_count_nxt = check_count_r;
    rows_nxt        = rows_r;
    if (!rst_n) begin
      code_length_nxt = CODE_LENGTH_RST;
      check_count_nxt = CHECK_COUNT_RST;
      rows_nxt        = ROW_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CODE_LENGTH: code_length_nxt = cfg_wdata[POS_W-1:0];
        REG_CHECK_COUNT: check_count_nxt = cfg_wdata[ROW_W-1:0];
        REG_ROW_ZERO:    rows_nxt[0]     = cfg_wdata;
        REG_ROW_ONE:     rows_nxt[1]     = cfg_wdata;
        REG_ROW_TWO:     rows_nxt[2]     = cfg_wdata;
        REG_ROW_THREE:   rows_nxt[3]     = cfg_wdata;
        REG_ROW_FOUR:    rows_nxt[4]     = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Tables are built from the next register values so an item taken right
  // after a write already sees them.
  always_comb begin
    tab_nxt = '0;
    tab_nxt.len  = (int'(code_length_nxt) > MAX_CODE_LENGTH) ?
                   POS_W'(MAX_CODE_LENGTH) : code_length_nxt;
    tab_nxt.rows = (int'(check_count_nxt) > ROW_CAP) ? ROW_W'(ROW_CAP) : check_count_nxt;

    for (int j = 0; j < WORD_W; j++) begin
      tab_nxt.len_mask[j] = (j < int'(tab_nxt.len));
    end

    for (int i = 0; i < ROW_REGS; i++) begin
      tab_nxt.row_mask[i] = (i < int'(tab_nxt.rows)) ? (rows_nxt[i] & tab_nxt.len_mask) : '0;
    end

    // parity column: exactly one active row selects it
    for (int j = 0; j < WORD_W; j++) begin
      for (int i = 0; i < ROW_REGS; i++) begin
        col_bits[i] = tab_nxt.row_mask[i][j];
      end
      par_cols[j] = ($countones(col_bits) == 1);
    end

    // only the lowest parity column of a row carries the row parity;
    // later ones of the same row always come out zero
    for (int i = 0; i < ROW_REGS; i++) begin
      pick = tab_nxt.row_mask[i] & par_cols;
      tab_nxt.first_par[i] = pick & (~pick + WORD_W'(1));
    end

    tab_nxt.data_cols = tab_nxt.len_mask & ~par_cols;

    for (int j = 0; j < WORD_W; j++) begin
      low_mask = (WORD_W'(1) << j) - WORD_W'(1);
      tab_nxt.data_idx[j] = POS_W'($countones(tab_nxt.data_cols & low_mask));
    end

    data_cnt = (POS_W+1)'($countones(tab_nxt.data_cols));
    for (int k = 0; k < WORD_W; k++) begin
      tab_nxt.data_keep[k] = (k < int'(data_cnt));
    end
  end

  always_ff @(posedge clk) begin
    code_length_r <= code_length_nxt;
    check_count_r <= check_count_nxt;
    rows_r        <= rows_nxt;
    tab_r         <= tab_nxt;
  end

  assign tab = tab_r;

endmodule

/* design/hmc_core.sv */
module hmc_core
  import hmc_pkg::*;
(
  input  hmc_in_t  in_word,
  input  hmc_cfg_t tab,
  output hmc_out_t res
);

  word_t               dword, enc_word;
  word_t               cw, flip, fixed, dec_data, match;
  logic [ROW_REGS-1:0] dpar, syn_bits;
  logic [POS_W-1:0]    syn;
  logic [ROW_W-1:0]    sel;

  // encode: scatter data bits, then drop each row parity into its column
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      dword[j] = tab.data_cols[j] & in_word.payload[tab.data_idx[j]];
    end
    enc_word = dword;
    for (int i = 0; i < ROW_REGS; i++) begin
      dpar[i]  = ^(dword & tab.row_mask[i]);
      enc_word = enc_word | (tab.first_par[i] & {WORD_W{dpar[i]}});
    end
  end

  // decode: syndrome, single-bit fix, gather data columns
  always_comb begin
    cw = in_word.payload & tab.len_mask;
    for (int i = 0; i < ROW_REGS; i++) begin
      syn_bits[i] = ^(cw & tab.row_mask[i]);
    end
    syn = '0;
    for (int b = 0; b < POS_W; b++) begin
      sel = ROW_W'(int'(tab.rows) - 1 - b);
      if (b < int'(tab.rows)) begin
        syn[b] = syn_bits[sel];
      end
    end

    flip = '0;
    res  = '0;
    if (syn != '0) begin
      if (syn <= tab.len) begin
        flip = WORD_W'(1) << (syn - POS_W'(1));
        res.error_position = syn;
      end else begin
        res.position_overflow = 1'b1;
      end
    end
    fixed = cw ^ flip;

    for (int k = 0; k < WORD_W; k++) begin
      for (int j = 0; j < WORD_W; j++) begin
        match[j] = (tab.data_idx[j] == POS_W'(k));
      end
      dec_data[k] = |(fixed & tab.data_cols & match);
    end

    if (in_word.opcode == OP_DECODE) begin
      res.result_word    = fixed;
      res.data_bits      = dec_data;
      res.syndrome_value = syn;
    end else begin
      res = '0;
      res.result_word = enc_word;
      res.data_bits   = in_word.payload & tab.data_keep;
    end
  end

endmodule

/* design/hamming_matrix_codec.sv */
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+-------------------------------------
// input    | start, busy, in_word           | word taken when start && !busy
// result   | out_valid, out_word            | one-cycle strobe, cannot be stalled
// config   | cfg_we, cfg_idx, cfg_wdata     | register written when cfg_we is high
//
// One word per clock, sustained; busy is tied low. A word taken at an edge
// lands in the input register; its result is registered in the output
// register, from which it is driven on out_word. The whole job per word
// is XOR trees plus scatter/gather muxes between those two registers.
// Reset (rst_n low, synchronous) clears both valid flags and loads the
// default 7,4 matrix. Config writes take effect for the very next word.
`include "hamming_matrix_codec_defines.svh"

module hamming_matrix_codec
  import hmc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             start,
  output logic             busy,
  input  hmc_in_t          in_word,
  // result channel
  output logic             out_valid,
  output hmc_out_t         out_word,
  // config port
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  word_t            cfg_wdata
);

  hmc_cfg_t tab;
  hmc_out_t res;

  logic     stg_vld_r, stg_vld_nxt;
  hmc_in_t  stg_word_r;
  logic     out_valid_r, out_valid_nxt;
  hmc_out_t out_word_r;

  // matrix registers and the column tables built from them
  hmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .tab       (tab)
  );

  // encode/decode datapath, purely combinational
  hmc_core u_core (
    .in_word (stg_word_r),
    .tab     (tab),
    .res     (res)
  );

  // no stall anywhere: a word can enter every cycle
  assign busy = 1'b0;

  assign stg_vld_nxt   = start && !busy;
  assign out_valid_nxt = stg_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_vld_r   <= stg_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: no reset, qualified by the valid flags
  always_ff @(posedge clk) begin
    if (stg_vld_nxt) begin
      stg_word_r <= in_word;
    end
    if (out_valid_nxt) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // every accepted word passes through the stage register to the result register
  `HMC_ASSERT_NEXT(a_take_to_stage, start && !busy, stg_vld_r)
  `HMC_ASSERT_NEXT(a_stage_to_out, stg_vld_r, out_valid_r)
  // a correction and an overflow flag never come together
  `HMC_ASSERT_NOW(a_fix_or_ovf, out_valid_r, !(out_word_r.position_overflow && out_word_r.error_position != '0))
  // a corrected position is always the syndrome itself
  `HMC_ASSERT_NOW(a_pos_is_syn, out_valid_r && out_word_r.error_position != '0, out_word_r.error_position == out_word_r.syndrome_value)

endmodule

/* tb/tb_hamming_matrix_codec.sv */
`timescale 1ns / 1ps

// Self-checking bench for the matrix-driven Hamming codec.
// A local predictor mirrors the config registers and computes the result
// word for every accepted input word; a monitor compares each strobed
// result against the oldest pending prediction.
module tb_hamming_matrix_codec;
  import hmc_pkg::*;

  localparam int CLK_HALF    = 6;       // 12 ns period
  localparam int RESET_LEN   = 6;
  localparam int CYCLE_LIMIT = 250000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  hmc_in_t          in_word;
  logic             out_valid;
  hmc_out_t         out_word;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  word_t            cfg_wdata;

  hamming_matrix_codec u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the config registers as the codec holds them.
  logic [POS_W-1:0] mat_len;
  logic [ROW_W-1:0] mat_checks;
  word_t            mat_row [ROW_REGS];

  // Matrix rows staged for the next program_matrix call.
  word_t            next_rows [ROW_REGS];

  hmc_out_t         pending_results [$];  // predictions waiting for their word
  int               err_count;
  int               cycle_count;
  int               gap_pct;              // odds (percent) of a start gap after a word

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Row that owns column col as its parity bit, or -1 when col is a data
  // column (zero or several active rows select it).
  function automatic int parity_row_of(int col, int rows);
    int hits;
    int owner;
    hits  = 0;
    owner = -1;
    for (int i = 0; i < rows; i++) begin
      if (mat_row[i][col]) begin
        hits++;
        owner = i;
      end
    end
    return (hits == 1) ? owner : -1;
  endfunction

  function automatic hmc_out_t predict_codec(hmc_in_t w);
    hmc_out_t         res;
    int               n;
    int               rows;
    int               k;
    int               owner;
    word_t            nmask;
    word_t            cw;
    word_t            keep;
    word_t            sel;
    logic [POS_W-1:0] syn;
    res   = '0;
    n     = (mat_len > MAX_CODE_LENGTH) ? MAX_CODE_LENGTH : int'(mat_len);
    rows  = (mat_checks > ROW_CAP) ? ROW_CAP : int'(mat_checks);
    nmask = '0;
    for (int j = 0; j < n; j++) nmask[j] = 1'b1;
    k    = 0;
    cw   = '0;
    keep = '0;
    syn  = '0;
    if (w.opcode == OP_ENCODE) begin
      // data bits fill the non-parity columns low to high
      for (int j = 0; j < n; j++) begin
        if (parity_row_of(j, rows) < 0) begin
          cw[j]   = w.payload[k];
          keep[k] = 1'b1;
          k++;
        end
      end
      // parity columns low to high; a later parity column of the same row
      // is still zero here, so it drops out of the XOR
      for (int j = 0; j < n; j++) begin
        owner = parity_row_of(j, rows);
        if (owner >= 0) begin
          sel    = mat_row[owner] & nmask;
          sel[j] = 1'b0;
          cw[j]  = ^(cw & sel);
        end
      end
      res.data_bits = w.payload & keep;
    end else begin
      cw = w.payload & nmask;
      for (int i = 0; i < rows; i++) syn = {syn[POS_W-2:0], ^(cw & mat_row[i] & nmask)};
      if (syn != '0) begin
        if (int'(syn) <= n) begin
          cw[syn - 1]        = ~cw[syn - 1];
          res.error_position = syn;
        end else begin
          res.position_overflow = 1'b1;  // out of range: word left alone
        end
      end
      for (int j = 0; j < n; j++) begin
        if (parity_row_of(j, rows) < 0) begin
          res.data_bits[k] = cw[j];
          k++;
        end
      end
    end
    res.result_word    = cw;
    res.syndrome_value = syn;
    return res;
  endfunction

  function automatic word_t codeword_of(word_t data);
    hmc_in_t  w;
    hmc_out_t p;
    w.opcode  = OP_ENCODE;
    w.payload = data;
    p         = predict_codec(w);
    return p.result_word;
  endfunction

  // ---------------------------------------------------------------------
  // Result monitor: the codec cannot be stalled, so every strobe counts.
  // ---------------------------------------------------------------------

  task automatic report_field(string fname, word_t want, word_t got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %h, got %h", $time, fname, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    hmc_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected word: expected none, got %h", $time, out_word);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        report_field("result_word", want.result_word, out_word.result_word);
        report_field("data_bits", want.data_bits, out_word.data_bits);
        report_field("syndrome_value", word_t'(want.syndrome_value),
                     word_t'(out_word.syndrome_value));
        report_field("error_position", word_t'(want.error_position),
                     word_t'(out_word.error_position));
        report_field("position_overflow", word_t'(want.position_overflow),
                     word_t'(out_word.position_overflow));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Present one word, hold it until start && !busy at an edge, then maybe
  // drop start for a random burst. start stays high between back-to-back
  // words, so it is never lowered and raised in the same step.
  task automatic issue_word(logic op, word_t payload);
    hmc_in_t w;
    w.opcode  = op;
    w.payload = payload;
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.insert(pending_results.size(), predict_codec(w));
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start   <= 1'b0;
      in_word <= hmc_in_t'($urandom);  // junk while idle, must be ignored
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Let the pipe empty before touching config.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(hmc_reg_t idx, word_t value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Write all seven registers; rows come from next_rows.
  task automatic program_matrix(int len, int checks);
    drain_results();
    write_reg(REG_CODE_LENGTH, word_t'(len[POS_W-1:0]));
    mat_len = len[POS_W-1:0];
    write_reg(REG_CHECK_COUNT, word_t'(checks[ROW_W-1:0]));
    mat_checks = checks[ROW_W-1:0];
    for (int i = 0; i < ROW_REGS; i++) begin
      write_reg(hmc_reg_t'(int'(REG_ROW_ZERO) + i), next_rows[i]);
      mat_row[i] = next_rows[i];
    end
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // Position-coded rows: column j carries j+1 in binary, row 0 the MSB, so
  // the syndrome of a single error is its 1-based position. Unused rows
  // get junk that the codec must ignore.
  function automatic void fill_standard_rows(int checks);
    logic [5:0] colnum;
    for (int i = 0; i < ROW_REGS; i++) begin
      next_rows[i] = word_t'($urandom);
      if (i < checks) begin
        for (int j = 0; j < WORD_W; j++) begin
          colnum          = 6'(j + 1);
          next_rows[i][j] = colnum[checks - 1 - i];
        end
      end
    end
  endfunction

  function automatic void pick_gap_pct();
    gap_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 60);
  endfunction

  // Mostly inside the code, now and then above it.
  function automatic int flip_spot(int len);
    if (len == 0 || $urandom_range(9) == 0) return $urandom_range(WORD_W - 1);
    return $urandom_range(len - 1);
  endfunction

  // One trial: a round trip (encode, then decode of that codeword with
  // zero, one or two flipped bits), or a lone encode, or a raw decode.
  task automatic exercise_codeword(int len);
    word_t data;
    word_t cw;
    int    pick;
    int    spot;
    data = word_t'($urandom);
    pick = $urandom_range(9);
    if (pick < 2) begin
      issue_word(OP_ENCODE, data);
    end else if (pick < 4) begin
      issue_word(OP_DECODE, word_t'($urandom));
    end else begin
      cw = codeword_of(data);
      issue_word(OP_ENCODE, data);
      if ($urandom_range(3) != 0) begin
        spot     = flip_spot(len);
        cw[spot] = ~cw[spot];
      end
      if ($urandom_range(6) == 0) begin
        spot     = flip_spot(len);
        cw[spot] = ~cw[spot];
      end
      issue_word(OP_DECODE, cw);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset matrix (7,4): clean words, all-ones with junk above n, and every
  // single-bit error position.
  task automatic test_default_matrix();
    word_t cw;
    gap_pct = 30;
    issue_word(OP_ENCODE, '0);
    issue_word(OP_ENCODE, 31'hF);
    issue_word(OP_ENCODE, 31'h7FFF_FFFF);
    issue_word(OP_ENCODE, 31'hA);
    issue_word(OP_DECODE, '0);
    issue_word(OP_DECODE, 31'h7FFF_FFFF);
    cw = codeword_of(31'hB);
    issue_word(OP_DECODE, cw);
    for (int p = 0; p < 7; p++) issue_word(OP_DECODE, cw ^ (word_t'(1) << p));
  endtask

  // Widest code: 31 columns, 5 rows, error at the top and bottom position.
  task automatic test_full_length();
    fill_standard_rows(5);
    program_matrix(31, 5);
    issue_word(OP_ENCODE, 31'h7FFF_FFFF);
    issue_word(OP_ENCODE, '0);
    issue_word(OP_DECODE, codeword_of(31'h7FFF_FFFF) ^ (word_t'(1) << 30));
    issue_word(OP_DECODE, 31'h1);
  endtask

  // n = 20 with 5 rows: double errors can point past the end of the code.
  task automatic test_syndrome_overflow();
    fill_standard_rows(5);
    program_matrix(20, 5);
    issue_word(OP_DECODE, (word_t'(1) << 15) | (word_t'(1) << 14));  // syndrome 31
    issue_word(OP_DECODE, (word_t'(1) << 19) | word_t'(1));          // syndrome 21
  endtask

  // Degenerate matrices: a row whose only column is its parity column,
  // a row owning several parity columns, no rows at all, row count above
  // the cap.
  task automatic test_odd_matrices();
    fill_standard_rows(3);
    next_rows[0] = 31'b0000001;
    next_rows[1] = 31'b0001110;
    next_rows[2] = 31'b1110100;
    program_matrix(7, 3);
    issue_word(OP_ENCODE, 31'h7FFF_FFFF);
    issue_word(OP_DECODE, 31'h7FFF_FFFF);
    program_matrix(5, 0);
    issue_word(OP_ENCODE, 31'h1F);
    issue_word(OP_DECODE, 31'h15);
    fill_standard_rows(5);
    program_matrix(3, 7);
    issue_word(OP_DECODE, 31'h7);
    issue_word(OP_ENCODE, 31'h1);
  endtask

  // Proper Hamming codes of random length; first the two extremes.
  task automatic test_random_hamming();
    int len;
    int checks;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) len = 31;
      else if (ph == 1) len = 3;
      else len = $urandom_range(3, 31);
      checks = 2;
      while ((1 << checks) - 1 < len) checks++;
      if (ph > 1) checks = $urandom_range(checks, 5);
      fill_standard_rows(checks);
      program_matrix(len, checks);
      pick_gap_pct();
      repeat (40) exercise_codeword(len);
    end
  endtask

  // Arbitrary matrices, lengths and row counts, including n = 0.
  task automatic test_random_matrices();
    int len;
    int checks;
    for (int ph = 0; ph < 4; ph++) begin
      len    = (ph == 0) ? 0 : $urandom_range(0, 31);
      checks = (ph == 1) ? 7 : $urandom_range(0, 7);
      for (int i = 0; i < ROW_REGS; i++) begin
        next_rows[i] = ($urandom_range(1) == 0) ? word_t'($urandom)
                                                : word_t'($urandom & $urandom);
        if (ph == 3 && i == 1) next_rows[i] = '1;
      end
      program_matrix(len, checks);
      pick_gap_pct();
      repeat (25) exercise_codeword(len);
    end
  endtask

  // Closing stretch at full rate, start held high throughout.
  task automatic test_streaming();
    fill_standard_rows(4);
    program_matrix(15, 4);
    gap_pct = 0;
    repeat (60) exercise_codeword(15);
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= REG_CODE_LENGTH;
    cfg_wdata <= '0;
    err_count   = 0;
    cycle_count = 0;
    gap_pct     = 0;
    // mirror starts at the reset values
    mat_len    = CODE_LENGTH_RST;
    mat_checks = CHECK_COUNT_RST;
    for (int i = 0; i < ROW_REGS; i++) mat_row[i] = ROW_RST[i];

    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_matrix();
    test_full_length();
    test_syndrome_overflow();
    test_odd_matrices();
    test_random_hamming();
    test_random_matrices();
    test_streaming();

    drain_results();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
